@@ rtl/core/cdc_pkg.sv @@
// ----------------------------------------------------------------------------
// cdc_pkg
// Shared types, tables and small arithmetic helpers for the calendar
// date/time check pipeline.
// ----------------------------------------------------------------------------
package cdc_pkg;

  // Largest valid value of each decimal field but the day, then month constants.
  localparam logic [6:0] YEAR_MAX   = 7'd99;
  localparam logic [3:0] MONTH_MAX  = 4'd12;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINUTE_MAX = 6'd59;
  localparam logic [5:0] SECOND_MAX = 6'd59;
  localparam logic [3:0] MONTH_FEB  = 4'd2;
  localparam logic [3:0] MONTH_MAR  = 4'd3;
  localparam logic [4:0] FEB_LEAP_LEN = 5'd29;
  // The year term of the weekday formula works on 100 + year offset.
  localparam logic [7:0] YEAR_BASE  = 8'd100;
  localparam logic [2:0] SUNDAY     = 3'd7;

  // Payload held in the first stage register.
  typedef struct packed {
    logic       bad;
    logic       leap;
    logic [3:0] month;
    logic [4:0] day;
    logic [2:0] weekday;
    logic       pm;
    logic [7:0] ysum;
    logic [7:0] year_bcd;
    logic [4:0] month_bcd;
    logic [5:0] day_bcd;
    logic [5:0] hour_bcd;
    logic [6:0] minute_bcd;
    logic [6:0] second_bcd;
  } s1_t;

  // Payload held in the second stage register.
  typedef struct packed {
    logic       bad;
    logic [5:0] tsum;
    logic [2:0] weekday;
    logic       pm;
    logic [7:0] year_bcd;
    logic [4:0] month_bcd;
    logic [5:0] day_bcd;
    logic [5:0] hour_bcd;
    logic [6:0] minute_bcd;
    logic [6:0] second_bcd;
  } s2_t;

  // Days in each month of a common year.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Month offsets of the weekday formula.
  function automatic logic [2:0] month_ofs(input logic [3:0] m);
    logic [2:0] ofs;
    case (m)
      4'd2, 4'd3, 4'd11: ofs = 3'd3;
      4'd4, 4'd7:        ofs = 3'd6;
      4'd5:              ofs = 3'd1;
      4'd6:              ofs = 3'd4;
      4'd8:              ofs = 3'd2;
      4'd9, 4'd12:       ofs = 3'd5;
      default:           ofs = 3'd0;
    endcase
    return ofs;
  endfunction

  // Remainder by seven: 36/256 never overshoots v/7, so the estimated
  // quotient is at most one short and one subtraction corrects it.
  function automatic logic [2:0] mod7(input logic [7:0] v);
    logic [15:0] p;
    logic [7:0]  q;
    logic [7:0]  r;
    p = 16'(v) * 16'd36;
    q = p[15:8];
    r = v - 8'(11'(q) * 11'd7);
    if (r >= 8'd7) begin
      r = r - 8'd7;
    end
    return r[2:0];
  endfunction

  // Two packed BCD digits of a value below 100; tens from 205/2048.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [17:0] p;
    logic [3:0]  tens;
    logic [7:0]  units;
    p     = 18'(v) * 18'd205;
    tens  = p[14:11];
    units = 8'(v) - 8'(tens) * 8'd10;
    return {tens, units[3:0]};
  endfunction

endpackage

@@ rtl/core/cdc_range_bcd.sv @@
// ----------------------------------------------------------------------------
// cdc_range_bcd
// First stage: field range checks, leap flag, BCD conversion and the
// raw year term of the weekday formula.
// ----------------------------------------------------------------------------
module cdc_range_bcd (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [6:0]    year_offset,
  input  logic [3:0]    month_num,
  input  logic [4:0]    day_of_month,
  input  logic [2:0]    weekday_in,
  input  logic [4:0]    hour_num,
  input  logic [5:0]    minute_num,
  input  logic [5:0]    second_num,
  input  logic          pm_flag,
  output logic          s1_vld,
  output cdc_pkg::s1_t  s1
);

  logic         vld_r;
  cdc_pkg::s1_t s1_r;
  cdc_pkg::s1_t s1_nxt;
  logic [7:0]   year_b;
  logic [7:0]   month_b;
  logic [7:0]   day_b;
  logic [7:0]   hour_b;
  logic [7:0]   minute_b;
  logic [7:0]   second_b;
  logic [7:0]   y;

  always_comb begin
    year_b   = cdc_pkg::to_bcd(year_offset);
    month_b  = cdc_pkg::to_bcd(7'(month_num));
    day_b    = cdc_pkg::to_bcd(7'(day_of_month));
    hour_b   = cdc_pkg::to_bcd(7'(hour_num));
    minute_b = cdc_pkg::to_bcd(7'(minute_num));
    second_b = cdc_pkg::to_bcd(7'(second_num));
    y        = cdc_pkg::YEAR_BASE + 8'(year_offset);

    s1_nxt.bad = (year_offset > cdc_pkg::YEAR_MAX) ||
                 (month_num == 4'd0) || (month_num > cdc_pkg::MONTH_MAX) ||
                 (day_of_month == 5'd0) || (weekday_in == 3'd0) ||
                 (hour_num > cdc_pkg::HOUR_MAX) ||
                 (minute_num > cdc_pkg::MINUTE_MAX) ||
                 (second_num > cdc_pkg::SECOND_MAX);
    // Within 2000..2099 only 2000 is a century year, and it is a leap year.
    s1_nxt.leap       = (year_offset[1:0] == 2'b00);
    s1_nxt.month      = month_num;
    s1_nxt.day        = day_of_month;
    s1_nxt.weekday    = weekday_in;
    s1_nxt.pm         = pm_flag;
    s1_nxt.ysum       = y + {2'b00, y[7:2]};
    s1_nxt.year_bcd   = year_b;
    s1_nxt.month_bcd  = month_b[4:0];
    s1_nxt.day_bcd    = day_b[5:0];
    s1_nxt.hour_bcd   = hour_b[5:0];
    s1_nxt.minute_bcd = minute_b[6:0];
    s1_nxt.second_bcd = second_b[6:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  assign s1_vld = vld_r;
  assign s1     = s1_r;

endmodule

@@ rtl/core/cdc_month_week.sv @@
// ----------------------------------------------------------------------------
// cdc_month_week
// Second stage: month length check and the unreduced weekday sum.
// ----------------------------------------------------------------------------
module cdc_month_week (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s1_vld,
  input  cdc_pkg::s1_t  s1,
  output logic          s2_vld,
  output cdc_pkg::s2_t  s2
);

  logic         vld_r;
  cdc_pkg::s2_t s2_r;
  cdc_pkg::s2_t s2_nxt;
  logic [4:0]   lim;
  logic [6:0]   t;

  always_comb begin
    lim = cdc_pkg::month_len(s1.month);
    if (s1.month == cdc_pkg::MONTH_FEB && s1.leap) begin
      lim = cdc_pkg::FEB_LEAP_LEN;
    end
    t = 7'(cdc_pkg::mod7(s1.ysum)) + 7'(s1.day) + 7'(cdc_pkg::month_ofs(s1.month));
    // January and February of a leap year count one day less.
    if (s1.leap && s1.month < cdc_pkg::MONTH_MAR) begin
      t = t - 7'd1;
    end

    s2_nxt.bad        = s1.bad || (s1.day > lim);
    s2_nxt.tsum       = t[5:0];
    s2_nxt.weekday    = s1.weekday;
    s2_nxt.pm         = s1.pm;
    s2_nxt.year_bcd   = s1.year_bcd;
    s2_nxt.month_bcd  = s1.month_bcd;
    s2_nxt.day_bcd    = s1.day_bcd;
    s2_nxt.hour_bcd   = s1.hour_bcd;
    s2_nxt.minute_bcd = s1.minute_bcd;
    s2_nxt.second_bcd = s1.second_bcd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
  end

  assign s2_vld = vld_r;
  assign s2     = s2_r;

endmodule

@@ rtl/core/cdc_result.sv @@
// ----------------------------------------------------------------------------
// cdc_result
// Third stage: final weekday reduction, zeroing of invalid beats and the
// output register.
// ----------------------------------------------------------------------------
module cdc_result (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s2_vld,
  input  cdc_pkg::s2_t  s2,
  output logic          out_valid,
  output logic          out_is_invalid,
  output logic [7:0]    out_year_bcd,
  output logic [4:0]    out_month_bcd,
  output logic [5:0]    out_day_bcd,
  output logic [2:0]    out_weekday_out,
  output logic [2:0]    out_weekday_calc,
  output logic [5:0]    out_hour_bcd,
  output logic [6:0]    out_minute_bcd,
  output logic [6:0]    out_second_bcd,
  output logic          out_pm_out
);

  logic       vld_r;
  logic       bad_r;
  logic [7:0] year_r;
  logic [4:0] month_r;
  logic [5:0] day_r;
  logic [2:0] wk_r;
  logic [2:0] wkc_r;
  logic [5:0] hour_r;
  logic [6:0] minute_r;
  logic [6:0] second_r;
  logic       pm_r;
  logic [2:0] wkc_nxt;
  logic       ok;

  always_comb begin
    wkc_nxt = cdc_pkg::mod7(8'(s2.tsum));
    if (wkc_nxt == 3'd0) begin
      wkc_nxt = cdc_pkg::SUNDAY;
    end
    ok = !s2.bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    bad_r    <= s2.bad;
    year_r   <= ok ? s2.year_bcd   : 8'd0;
    month_r  <= ok ? s2.month_bcd  : 5'd0;
    day_r    <= ok ? s2.day_bcd    : 6'd0;
    wk_r     <= ok ? s2.weekday    : 3'd0;
    wkc_r    <= ok ? wkc_nxt       : 3'd0;
    hour_r   <= ok ? s2.hour_bcd   : 6'd0;
    minute_r <= ok ? s2.minute_bcd : 7'd0;
    second_r <= ok ? s2.second_bcd : 7'd0;
    pm_r     <= ok && s2.pm;
  end

  assign out_valid        = vld_r;
  assign out_is_invalid   = bad_r;
  assign out_year_bcd     = year_r;
  assign out_month_bcd    = month_r;
  assign out_day_bcd      = day_r;
  assign out_weekday_out  = wk_r;
  assign out_weekday_calc = wkc_r;
  assign out_hour_bcd     = hour_r;
  assign out_minute_bcd   = minute_r;
  assign out_second_bcd   = second_r;
  assign out_pm_out       = pm_r;

endmodule

@@ rtl/core/calendar_datetime_check_bcd_unit.sv @@
// ----------------------------------------------------------------------------
// calendar_datetime_check_bcd_unit
// Checks a decimal calendar date/time, converts it to packed BCD and
// computes the weekday from the date.
// ----------------------------------------------------------------------------
//
//   Channel  | Handshake          | Fields
//   ---------+--------------------+-----------------------------------------
//   input    | start, busy        | in_year_offset .. in_pm_flag
//   result   | out_valid (strobe) | out_is_invalid .. out_pm_out
//
// Three register stages: range checks and BCD, month length and weekday sum,
// weekday reduction and output register. One beat is taken every cycle and
// its result goes through the stage registers and shows for one cycle only.
// busy never rises, as the pipeline has no stall path.
// Synchronous reset clears the stage valid bits; nothing else needs it.
// ----------------------------------------------------------------------------
module calendar_datetime_check_bcd_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [6:0] in_year_offset,
  input  logic [3:0] in_month_num,
  input  logic [4:0] in_day_of_month,
  input  logic [2:0] in_weekday_in,
  input  logic [4:0] in_hour_num,
  input  logic [5:0] in_minute_num,
  input  logic [5:0] in_second_num,
  input  logic       in_pm_flag,
  output logic       out_valid,
  output logic       out_is_invalid,
  output logic [7:0] out_year_bcd,
  output logic [4:0] out_month_bcd,
  output logic [5:0] out_day_bcd,
  output logic [2:0] out_weekday_out,
  output logic [2:0] out_weekday_calc,
  output logic [5:0] out_hour_bcd,
  output logic [6:0] out_minute_bcd,
  output logic [6:0] out_second_bcd,
  output logic       out_pm_out
);

  logic         s1_vld;
  cdc_pkg::s1_t s1;
  logic         s2_vld;
  cdc_pkg::s2_t s2;

  assign busy = 1'b0;

  cdc_range_bcd u_range_bcd (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (start),
    .year_offset  (in_year_offset),
    .month_num    (in_month_num),
    .day_of_month (in_day_of_month),
    .weekday_in   (in_weekday_in),
    .hour_num     (in_hour_num),
    .minute_num   (in_minute_num),
    .second_num   (in_second_num),
    .pm_flag      (in_pm_flag),
    .s1_vld       (s1_vld),
    .s1           (s1)
  );

  cdc_month_week u_month_week (
    .clk    (clk),
    .rst_n  (rst_n),
    .s1_vld (s1_vld),
    .s1     (s1),
    .s2_vld (s2_vld),
    .s2     (s2)
  );

  cdc_result u_result (
    .clk              (clk),
    .rst_n            (rst_n),
    .s2_vld           (s2_vld),
    .s2               (s2),
    .out_valid        (out_valid),
    .out_is_invalid   (out_is_invalid),
    .out_year_bcd     (out_year_bcd),
    .out_month_bcd    (out_month_bcd),
    .out_day_bcd      (out_day_bcd),
    .out_weekday_out  (out_weekday_out),
    .out_weekday_calc (out_weekday_calc),
    .out_hour_bcd     (out_hour_bcd),
    .out_minute_bcd   (out_minute_bcd),
    .out_second_bcd   (out_second_bcd),
    .out_pm_out       (out_pm_out)
  );

endmodule

@@ tb/datetime_bcd_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// datetime_bcd_checker
// Watches the input and result channels of the calendar check unit. For
// every accepted date/time beat it predicts the validity flag, the packed
// BCD fields and the computed weekday. It compares each result beat field
// by field with the oldest prediction and keeps a mismatch count for the
// top level.
// ----------------------------------------------------------------------------
module datetime_bcd_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [6:0] in_year_offset,
  input  logic [3:0] in_month_num,
  input  logic [4:0] in_day_of_month,
  input  logic [2:0] in_weekday_in,
  input  logic [4:0] in_hour_num,
  input  logic [5:0] in_minute_num,
  input  logic [5:0] in_second_num,
  input  logic       in_pm_flag,
  input  logic       out_valid,
  input  logic       out_is_invalid,
  input  logic [7:0] out_year_bcd,
  input  logic [4:0] out_month_bcd,
  input  logic [5:0] out_day_bcd,
  input  logic [2:0] out_weekday_out,
  input  logic [2:0] out_weekday_calc,
  input  logic [5:0] out_hour_bcd,
  input  logic [6:0] out_minute_bcd,
  input  logic [6:0] out_second_bcd,
  input  logic       out_pm_out,
  output int         mismatch_count,
  output int         pending_count,
  output int         valid_count,
  output int         invalid_count
);

  typedef struct packed {
    logic       is_invalid;
    logic [7:0] year_bcd;
    logic [4:0] month_bcd;
    logic [5:0] day_bcd;
    logic [2:0] weekday_out;
    logic [2:0] weekday_calc;
    logic [5:0] hour_bcd;
    logic [6:0] minute_bcd;
    logic [6:0] second_bcd;
    logic       pm_out;
  } bcd_time_t;

  bcd_time_t expected_bcd_times[$];
  bcd_time_t oldest_time;
  bcd_time_t new_time;
  int        field_errors;
  int        valid_seen;
  int        invalid_seen;

  function automatic int days_in_month(input logic [3:0] month, input bit leap);
    int days;
    case (month)
      cdc_pkg::MONTH_FEB:          days = leap ? 29 : 28;
      4'd4, 4'd6, 4'd9, 4'd11:     days = 30;
      default:                     days = 31;
    endcase
    return days;
  endfunction

  // Per-month term of the weekday sum, January first.
  function automatic int month_offset(input logic [3:0] month);
    int ofs;
    case (month)
      4'd1:  ofs = 0;
      4'd2:  ofs = 3;
      4'd3:  ofs = 3;
      4'd4:  ofs = 6;
      4'd5:  ofs = 1;
      4'd6:  ofs = 4;
      4'd7:  ofs = 6;
      4'd8:  ofs = 2;
      4'd9:  ofs = 5;
      4'd10: ofs = 0;
      4'd11: ofs = 3;
      default: ofs = 5;
    endcase
    return ofs;
  endfunction

  function automatic logic [7:0] packed_bcd(input int value);
    return {4'(value / 10), 4'(value % 10)};
  endfunction

  function automatic bcd_time_t predict_bcd_time(
    input logic [6:0] year_ofs,
    input logic [3:0] month,
    input logic [4:0] day,
    input logic [2:0] weekday,
    input logic [4:0] hour,
    input logic [5:0] minute,
    input logic [5:0] second,
    input logic       pm
  );
    bcd_time_t result;
    int        cal_year;
    int        year_term;
    int        dow;
    bit        leap;
    bit        bad;
    result   = '0;
    cal_year = 2000 + year_ofs;
    leap     = ((cal_year % 4 == 0) && (cal_year % 100 != 0)) || (cal_year % 400 == 0);
    bad = (year_ofs > cdc_pkg::YEAR_MAX) || (month == 4'd0) ||
          (month > cdc_pkg::MONTH_MAX) || (day == 5'd0) || (weekday == 3'd0) ||
          (hour > cdc_pkg::HOUR_MAX) || (minute > cdc_pkg::MINUTE_MAX) ||
          (second > cdc_pkg::SECOND_MAX);
    if (!bad && (day > days_in_month(month, leap))) begin
      bad = 1'b1;
    end
    if (bad) begin
      result.is_invalid = 1'b1;
      return result;
    end
    year_term = 100 + year_ofs;
    dow = (year_term + year_term / 4) % 7 + day + month_offset(month);
    // January and February of a leap year come before the extra day.
    if (leap && (month < cdc_pkg::MONTH_MAR)) begin
      dow = dow - 1;
    end
    dow = dow % 7;
    if (dow == 0) begin
      dow = cdc_pkg::SUNDAY;
    end
    result.year_bcd     = packed_bcd(year_ofs);
    result.month_bcd    = 5'(packed_bcd(month));
    result.day_bcd      = 6'(packed_bcd(day));
    result.weekday_out  = weekday;
    result.weekday_calc = 3'(dow);
    result.hour_bcd     = 6'(packed_bcd(hour));
    result.minute_bcd   = 7'(packed_bcd(minute));
    result.second_bcd   = 7'(packed_bcd(second));
    result.pm_out       = pm;
    return result;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      field_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (expected_bcd_times.size() == 0) begin
          $error("result beat arrived with no date/time waiting for it");
          field_errors++;
        end else begin
          oldest_time = expected_bcd_times.pop_front();
          check_field("is_invalid", 8'(oldest_time.is_invalid), 8'(out_is_invalid));
          check_field("year_bcd", oldest_time.year_bcd, out_year_bcd);
          check_field("month_bcd", 8'(oldest_time.month_bcd), 8'(out_month_bcd));
          check_field("day_bcd", 8'(oldest_time.day_bcd), 8'(out_day_bcd));
          check_field("weekday_out", 8'(oldest_time.weekday_out), 8'(out_weekday_out));
          check_field("weekday_calc", 8'(oldest_time.weekday_calc), 8'(out_weekday_calc));
          check_field("hour_bcd", 8'(oldest_time.hour_bcd), 8'(out_hour_bcd));
          check_field("minute_bcd", 8'(oldest_time.minute_bcd), 8'(out_minute_bcd));
          check_field("second_bcd", 8'(oldest_time.second_bcd), 8'(out_second_bcd));
          check_field("pm_out", 8'(oldest_time.pm_out), 8'(out_pm_out));
        end
      end
      if (start && !busy) begin
        new_time = predict_bcd_time(in_year_offset, in_month_num, in_day_of_month,
                                    in_weekday_in, in_hour_num, in_minute_num,
                                    in_second_num, in_pm_flag);
        expected_bcd_times.push_back(new_time);
        if (new_time.is_invalid) begin
          invalid_seen++;
        end else begin
          valid_seen++;
        end
      end
    end
    // Counts are published with nonblocking updates so that the top level
    // always reads the value settled at the previous edge.
    mismatch_count <= field_errors;
    pending_count  <= expected_bcd_times.size();
    valid_count    <= valid_seen;
    invalid_count  <= invalid_seen;
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the calendar date/time check unit. A directed
// set of corner dates and times is followed by random beats, mostly
// well-formed dates with random content, under three idling phases of
// the sender. The checker beside the block does all prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int STALL_LIMIT  = 500;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BEATS  = 700;

  typedef enum int {
    BREAK_YEAR,
    BREAK_MONTH,
    BREAK_DAY,
    BREAK_WEEKDAY,
    BREAK_HOUR,
    BREAK_MINUTE,
    BREAK_SECOND
  } broken_field_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [6:0] in_year_offset;
  logic [3:0] in_month_num;
  logic [4:0] in_day_of_month;
  logic [2:0] in_weekday_in;
  logic [4:0] in_hour_num;
  logic [5:0] in_minute_num;
  logic [5:0] in_second_num;
  logic       in_pm_flag;
  logic       out_valid;
  logic       out_is_invalid;
  logic [7:0] out_year_bcd;
  logic [4:0] out_month_bcd;
  logic [5:0] out_day_bcd;
  logic [2:0] out_weekday_out;
  logic [2:0] out_weekday_calc;
  logic [5:0] out_hour_bcd;
  logic [6:0] out_minute_bcd;
  logic [6:0] out_second_bcd;
  logic       out_pm_out;

  int mismatch_count;
  int pending_count;
  int valid_count;
  int invalid_count;
  int idle_pct;
  int quiet_cycles;

  calendar_datetime_check_bcd_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_year_offset   (in_year_offset),
    .in_month_num     (in_month_num),
    .in_day_of_month  (in_day_of_month),
    .in_weekday_in    (in_weekday_in),
    .in_hour_num      (in_hour_num),
    .in_minute_num    (in_minute_num),
    .in_second_num    (in_second_num),
    .in_pm_flag       (in_pm_flag),
    .out_valid        (out_valid),
    .out_is_invalid   (out_is_invalid),
    .out_year_bcd     (out_year_bcd),
    .out_month_bcd    (out_month_bcd),
    .out_day_bcd      (out_day_bcd),
    .out_weekday_out  (out_weekday_out),
    .out_weekday_calc (out_weekday_calc),
    .out_hour_bcd     (out_hour_bcd),
    .out_minute_bcd   (out_minute_bcd),
    .out_second_bcd   (out_second_bcd),
    .out_pm_out       (out_pm_out)
  );

  datetime_bcd_checker u_bcd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_year_offset   (in_year_offset),
    .in_month_num     (in_month_num),
    .in_day_of_month  (in_day_of_month),
    .in_weekday_in    (in_weekday_in),
    .in_hour_num      (in_hour_num),
    .in_minute_num    (in_minute_num),
    .in_second_num    (in_second_num),
    .in_pm_flag       (in_pm_flag),
    .out_valid        (out_valid),
    .out_is_invalid   (out_is_invalid),
    .out_year_bcd     (out_year_bcd),
    .out_month_bcd    (out_month_bcd),
    .out_day_bcd      (out_day_bcd),
    .out_weekday_out  (out_weekday_out),
    .out_weekday_calc (out_weekday_calc),
    .out_hour_bcd     (out_hour_bcd),
    .out_minute_bcd   (out_minute_bcd),
    .out_second_bcd   (out_second_bcd),
    .out_pm_out       (out_pm_out),
    .mismatch_count   (mismatch_count),
    .pending_count    (pending_count),
    .valid_count      (valid_count),
    .invalid_count    (invalid_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // A quiet stretch that reaches STALL_LIMIT, with neither an accepted beat nor a result, ends the run.
  always @(posedge clk) begin
    if ((start && !busy) || (out_valid === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // Holds one beat on the input until the block takes it, after an
  // optional random idle stretch.
  task automatic send_time(
    input logic [6:0] year_ofs,
    input logic [3:0] month,
    input logic [4:0] day,
    input logic [2:0] weekday,
    input logic [4:0] hour,
    input logic [5:0] minute,
    input logic [5:0] second,
    input logic       pm
  );
    if ((idle_pct > 0) && ($urandom_range(99) < idle_pct)) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start           <= 1'b1;
    in_year_offset  <= year_ofs;
    in_month_num    <= month;
    in_day_of_month <= day;
    in_weekday_in   <= weekday;
    in_hour_num     <= hour;
    in_minute_num   <= minute;
    in_second_num   <= second;
    in_pm_flag      <= pm;
    do @(posedge clk); while (busy);
  endtask

  task automatic random_time_beat();
    logic [6:0]    year_ofs;
    logic [3:0]    month;
    logic [4:0]    day;
    logic [2:0]    weekday;
    logic [4:0]    hour;
    logic [5:0]    minute;
    logic [5:0]    second;
    logic          pm;
    int            mix;
    int            pick;
    broken_field_t broken;
    mix = $urandom_range(99);
    if (mix >= 85) begin
      // Raw noise: every bit of every field free.
      year_ofs = 7'($urandom);
      month    = 4'($urandom);
      day      = 5'($urandom);
      weekday  = 3'($urandom);
      hour     = 5'($urandom);
      minute   = 6'($urandom);
      second   = 6'($urandom);
      pm       = 1'($urandom);
    end else begin
      year_ofs = 7'($urandom_range(cdc_pkg::YEAR_MAX));
      month    = 4'($urandom_range(cdc_pkg::MONTH_MAX, 1));
      // Month ends are favoured so that the length check is hit often.
      if ($urandom_range(3) == 0) begin
        day = 5'($urandom_range(31, 28));
      end else begin
        day = 5'($urandom_range(31, 1));
      end
      weekday = 3'($urandom_range(cdc_pkg::SUNDAY, 1));
      hour    = 5'($urandom_range(cdc_pkg::HOUR_MAX));
      minute  = 6'($urandom_range(cdc_pkg::MINUTE_MAX));
      second  = 6'($urandom_range(cdc_pkg::SECOND_MAX));
      pm      = 1'($urandom);
      if (mix >= 70) begin
        broken = broken_field_t'($urandom_range(BREAK_SECOND));
        case (broken)
          BREAK_YEAR:    year_ofs = 7'($urandom_range(127, 100));
          BREAK_MONTH: begin
            pick  = $urandom_range(3);
            month = (pick == 0) ? 4'd0 : 4'(12 + pick);
          end
          BREAK_DAY:     day = 5'd0;
          BREAK_WEEKDAY: weekday = 3'd0;
          BREAK_HOUR:    hour = 5'($urandom_range(31, 24));
          BREAK_MINUTE:  minute = 6'($urandom_range(63, 60));
          default:       second = 6'($urandom_range(63, 60));
        endcase
      end
    end
    send_time(year_ofs, month, day, weekday, hour, minute, second, pm);
  endtask

  initial begin
    idle_pct        = 34;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_year_offset  <= '0;
    in_month_num    <= '0;
    in_day_of_month <= '0;
    in_weekday_in   <= '0;
    in_hour_num     <= '0;
    in_minute_num   <= '0;
    in_second_num   <= '0;
    in_pm_flag      <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes.
    send_time(7'd0, 4'd0, 5'd0, 3'd0, 5'd0, 6'd0, 6'd0, 1'b0);
    send_time(7'd127, 4'd15, 5'd31, 3'd7, 5'd31, 6'd63, 6'd63, 1'b1);
    send_time(7'd0, 4'd1, 5'd1, 3'd1, 5'd0, 6'd0, 6'd0, 1'b0);
    send_time(7'd99, 4'd12, 5'd31, 3'd7, 5'd23, 6'd59, 6'd59, 1'b1);
    // One field just out of range at a time.
    send_time(7'd100, 4'd6, 5'd15, 3'd3, 5'd12, 6'd30, 6'd30, 1'b0);
    send_time(7'd24, 4'd13, 5'd15, 3'd3, 5'd12, 6'd30, 6'd30, 1'b0);
    send_time(7'd24, 4'd6, 5'd0, 3'd3, 5'd12, 6'd30, 6'd30, 1'b0);
    send_time(7'd24, 4'd6, 5'd15, 3'd0, 5'd12, 6'd30, 6'd30, 1'b0);
    send_time(7'd24, 4'd6, 5'd15, 3'd3, 5'd24, 6'd30, 6'd30, 1'b0);
    send_time(7'd24, 4'd6, 5'd15, 3'd3, 5'd12, 6'd60, 6'd30, 1'b0);
    send_time(7'd24, 4'd6, 5'd15, 3'd3, 5'd12, 6'd30, 6'd60, 1'b0);
    // Month lengths, including the century leap year and common years.
    send_time(7'd23, 4'd4, 5'd30, 3'd7, 5'd8, 6'd15, 6'd0, 1'b0);
    send_time(7'd23, 4'd4, 5'd31, 3'd1, 5'd8, 6'd15, 6'd0, 1'b0);
    send_time(7'd0, 4'd2, 5'd29, 3'd2, 5'd10, 6'd0, 6'd0, 1'b0);
    send_time(7'd4, 4'd2, 5'd29, 3'd7, 5'd10, 6'd0, 6'd0, 1'b0);
    send_time(7'd1, 4'd2, 5'd29, 3'd4, 5'd10, 6'd0, 6'd0, 1'b0);
    send_time(7'd1, 4'd2, 5'd28, 3'd3, 5'd10, 6'd0, 6'd0, 1'b0);
    send_time(7'd24, 4'd2, 5'd30, 3'd5, 5'd10, 6'd0, 6'd0, 1'b0);
    // January of a leap year takes the one-day correction.
    send_time(7'd24, 4'd1, 5'd15, 3'd1, 5'd9, 6'd45, 6'd12, 1'b0);
    send_time(7'd23, 4'd3, 5'd1, 3'd3, 5'd9, 6'd45, 6'd12, 1'b0);
    // Given weekdays that agree and disagree with the date; a disagreeing one is still valid.
    send_time(7'd24, 4'd7, 5'd4, 3'd7, 5'd17, 6'd5, 6'd59, 1'b1);
    send_time(7'd24, 4'd12, 5'd25, 3'd3, 5'd12, 6'd0, 6'd0, 1'b1);
    send_time(7'd99, 4'd12, 5'd31, 3'd4, 5'd0, 6'd59, 6'd1, 1'b0);

    idle_pct = 34;
    repeat (PHASE_BEATS) random_time_beat();
    idle_pct = 50;
    repeat (PHASE_BEATS) random_time_beat();
    idle_pct = 0;
    repeat (PHASE_BEATS) random_time_beat();
    start <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d date/time beats: %0d valid, %0d rejected.",
             valid_count + invalid_count, valid_count, invalid_count);
    $display("Corner dates first, then random beats under three sender idling mixes.");
    if ((mismatch_count == 0) && (pending_count == 0)) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ calendar_datetime_check_bcd_unit.f @@
rtl/core/cdc_pkg.sv
rtl/core/cdc_range_bcd.sv
rtl/core/cdc_month_week.sv
rtl/core/cdc_result.sv
rtl/core/calendar_datetime_check_bcd_unit.sv
tb/datetime_bcd_checker.sv
tb/testbench.sv
